// File: rtl/core/pixel_luma_box_downscale_defines.svh
// Assertion helpers shared by the RTL; every user has clk and rst_n in scope.
`ifndef PIXEL_LUMA_BOX_DOWNSCALE_DEFINES_SVH
`define PIXEL_LUMA_BOX_DOWNSCALE_DEFINES_SVH

// Same-cycle implication.
`define PLBD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PLBD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/plbd_pkg.sv
package plbd_pkg;

    localparam int DEF_MAX_GRID_COLUMNS = 64;
    localparam int DEF_MAX_GRID_ROWS    = 64;
    localparam int DEF_MAX_SOURCE_SIZE  = 1024;

    localparam int PIXEL_W    = 32;
    localparam int ROW_FW     = 6;
    localparam int COL_FW     = 6;
    localparam int BRIGHT_W   = 8;
    localparam int SIZE_REG_W = 11;
    localparam int GRID_REG_W = 7;
    localparam int FMT_REG_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int LUMA_R_WEIGHT = 77;
    localparam int LUMA_G_WEIGHT = 151;
    localparam int LUMA_B_WEIGHT = 28;
    localparam int LUMA_MAX      = 255;
    localparam logic [4:0] RB5_MASK = 5'h1F;
    localparam logic [5:0] G6_MASK  = 6'h3F;

    typedef enum logic [FMT_REG_W-1:0] {
        FMT_RGB565   = 2'd0,
        FMT_ARGB8888 = 2'd1,
        FMT_NONE     = 2'd2
    } pixel_format_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 3'd0,
        REG_SOURCE_HEIGHT = 3'd1,
        REG_GRID_COLUMNS  = 3'd2,
        REG_GRID_ROWS     = 3'd3,
        REG_PIXEL_FORMAT  = 3'd4
    } cfg_reg_t;

    // Command bundle to the cell accumulator store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_one;
        logic clr_all;
    } store_cmd_t;

endpackage

// File: rtl/core/plbd_pixel_if.sv
interface plbd_pixel_if;
    import plbd_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

// File: rtl/core/plbd_cell_if.sv
interface plbd_cell_if;
    import plbd_pkg::*;

    logic                valid;
    logic                ready;
    logic [ROW_FW-1:0]   cell_row;
    logic [COL_FW-1:0]   cell_column;
    logic [BRIGHT_W-1:0] cell_brightness;
    logic                last_in_band;
    logic                shape_error;

    modport source (
        output valid, output cell_row, output cell_column, output cell_brightness,
        output last_in_band, output shape_error, input ready
    );
    modport sink (
        input valid, input cell_row, input cell_column, input cell_brightness,
        input last_in_band, input shape_error, output ready
    );
endinterface

// File: rtl/core/pixel_luma_box_downscale.sv
// Luma box-filter downscaler.
// Channels: "pixel" (sink) takes one source pixel per transfer in raster order;
// "grid" (source) gives one grid cell per transfer: row, column, average luma,
// last_in_band on the final cell of a band, shape_error when height < grid rows.
// Configuration: cfg_write with cfg_index/cfg_data; any listed register write
// restarts the image at pixel (0, 0) and empties every cell accumulator.
// Flow: after a pixel is taken the input stays busy through its cell search,
// then a read and a write of the single-port cell memory; a column edge and a
// band edge are stepped in the same cycle, so the search lasts as many steps as
// the larger of the two.
// On the last pixel of a band the block then emits grid_columns cells, each in
// turn by memory read, quotient unit and output load. No pixel is
// taken during emission. A finished cell waits in the output register, so a
// following pixel is accepted even while the receiver stalls; a stalled output
// only holds back the next cell of an emission.
// Reset: registers return to 1x1 image, 1x1 grid, RGB565; valid bits of all
// cells clear at once, so no clearing pass is needed.
`include "pixel_luma_box_downscale_defines.svh"

module pixel_luma_box_downscale #(
    parameter int MAX_GRID_COLUMNS = plbd_pkg::DEF_MAX_GRID_COLUMNS,
    parameter int MAX_GRID_ROWS    = plbd_pkg::DEF_MAX_GRID_ROWS,
    parameter int MAX_SOURCE_SIZE  = plbd_pkg::DEF_MAX_SOURCE_SIZE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    plbd_pixel_if.sink                        pixel,
    plbd_cell_if.source                       grid,
    input  logic                              cfg_write,
    input  logic [plbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [plbd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import plbd_pkg::*;

    localparam int SZ_W = $clog2(MAX_SOURCE_SIZE + 1);
    localparam int XW   = $clog2(MAX_SOURCE_SIZE);
    localparam int GC_W = $clog2(MAX_GRID_COLUMNS + 1);
    localparam int GR_W = $clog2(MAX_GRID_ROWS + 1);
    localparam int CI_W = (MAX_GRID_COLUMNS > 1) ? $clog2(MAX_GRID_COLUMNS) : 1;
    localparam int BI_W = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
    localparam longint PIX_MAX = longint'(MAX_SOURCE_SIZE) * longint'(MAX_SOURCE_SIZE);
    localparam int CNT_W = $clog2(PIX_MAX + 1);
    localparam int SUM_W = $clog2(PIX_MAX * longint'(LUMA_MAX) + 1);
    localparam int CPW  = GC_W + SZ_W;
    localparam int BPW  = GR_W + SZ_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_READ,
        S_UPDATE,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_DIV,
        S_EMIT_OUT
    } state_t;

    // configuration registers
    logic [SIZE_REG_W-1:0] width_reg, width_next;
    logic [SIZE_REG_W-1:0] height_reg, height_next;
    logic [GRID_REG_W-1:0] cols_reg, cols_next;
    logic [GRID_REG_W-1:0] rows_reg, rows_next;
    logic [FMT_REG_W-1:0]  fmt_reg, fmt_next;
    logic                  cfg_restart;

    // effective (clamped) sizes
    logic [SZ_W-1:0] w_eff;
    logic [SZ_W-1:0] h_eff;
    logic [GC_W-1:0] c_eff;
    logic [GR_W-1:0] r_eff;

    state_t          state_reg;
    logic [XW-1:0]   x_reg;
    logic [XW-1:0]   y_reg;
    logic [CI_W-1:0] cc_reg;
    logic [BI_W-1:0] band_reg;
    logic [CI_W-1:0] k_reg;
    logic            row_start_reg;
    logic [PIXEL_W-1:0] word_reg;

    logic                out_valid_reg;
    logic [ROW_FW-1:0]   out_row_reg;
    logic [COL_FW-1:0]   out_col_reg;
    logic [BRIGHT_W-1:0] out_bright_reg;
    logic                out_last_reg;
    logic                out_err_reg;

    // boundary compare unit
    logic [GC_W-1:0] cc_inc;
    logic [SZ_W-1:0] x1;
    logic [CPW-1:0]  col_lhs;
    logic [CPW-1:0]  col_rhs;
    logic            col_step;
    logic [GR_W-1:0] band_inc;
    logic [SZ_W-1:0] y1;
    logic [BPW-1:0]  band_mh;
    logic [BPW-1:0]  band_y1r;
    logic [BPW-1:0]  band_y2r;
    logic            band_step;
    logic            band_end;
    logic            last_col;
    logic            last_row;
    logic            shape_err;
    logic [GC_W-1:0] k_inc;
    logic            k_last;

    logic                 pixel_accept;
    logic                 out_load;
    store_cmd_t           store_cmd;
    logic [CI_W-1:0]      store_addr;
    logic [SUM_W-1:0]     rd_sum;
    logic [CNT_W-1:0]     rd_count;
    logic [SUM_W-1:0]     wr_sum;
    logic [CNT_W-1:0]     wr_count;
    logic [BRIGHT_W-1:0]  luma;
    logic                 div_done;
    logic [BRIGHT_W-1:0]  div_quot;

    // ---------------------------------------------------------------
    // Configuration decode. Writes to unlisted indexes are dropped.
    // ---------------------------------------------------------------
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        cols_next   = cols_reg;
        rows_next   = rows_reg;
        fmt_next    = fmt_reg;
        cfg_restart = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:
                begin
                    width_next  = cfg_data[SIZE_REG_W-1:0];
                    cfg_restart = 1'b1;
                end
                REG_SOURCE_HEIGHT:
                begin
                    height_next = cfg_data[SIZE_REG_W-1:0];
                    cfg_restart = 1'b1;
                end
                REG_GRID_COLUMNS:
                begin
                    cols_next   = cfg_data[GRID_REG_W-1:0];
                    cfg_restart = 1'b1;
                end
                REG_GRID_ROWS:
                begin
                    rows_next   = cfg_data[GRID_REG_W-1:0];
                    cfg_restart = 1'b1;
                end
                REG_PIXEL_FORMAT:
                begin
                    fmt_next    = cfg_data[FMT_REG_W-1:0];
                    cfg_restart = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_REG_W'(1);
            height_reg <= SIZE_REG_W'(1);
            cols_reg   <= GRID_REG_W'(1);
            rows_reg   <= GRID_REG_W'(1);
            fmt_reg    <= FMT_RGB565;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            cols_reg   <= cols_next;
            rows_reg   <= rows_next;
            fmt_reg    <= fmt_next;
        end
    end

    // Saturate zero and oversize register values into the legal ranges.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = SZ_W'(1);
        else if (int'(width_reg) > MAX_SOURCE_SIZE)
            w_eff = SZ_W'(MAX_SOURCE_SIZE);
        else
            w_eff = SZ_W'(width_reg);

        if (height_reg == '0)
            h_eff = SZ_W'(1);
        else if (int'(height_reg) > MAX_SOURCE_SIZE)
            h_eff = SZ_W'(MAX_SOURCE_SIZE);
        else
            h_eff = SZ_W'(height_reg);

        if (cols_reg == '0)
            c_eff = GC_W'(1);
        else if (int'(cols_reg) > MAX_GRID_COLUMNS)
            c_eff = GC_W'(MAX_GRID_COLUMNS);
        else
            c_eff = GC_W'(cols_reg);

        if (rows_reg == '0)
            r_eff = GR_W'(1);
        else if (int'(rows_reg) > MAX_GRID_ROWS)
            r_eff = GR_W'(MAX_GRID_ROWS);
        else
            r_eff = GR_W'(rows_reg);
    end

    // ---------------------------------------------------------------
    // Cell boundaries: column c starts at floor(c*W/C), so x lies at or
    // past that start exactly when c*W < (x+1)*C. Bands likewise.
    // ---------------------------------------------------------------
    always_comb
    begin
        cc_inc    = GC_W'(cc_reg) + GC_W'(1);
        x1        = SZ_W'(x_reg) + SZ_W'(1);
        col_lhs   = CPW'(cc_inc) * CPW'(w_eff);
        col_rhs   = CPW'(x1) * CPW'(c_eff);
        col_step  = (cc_inc < c_eff) && (col_lhs < col_rhs);

        band_inc  = GR_W'(band_reg) + GR_W'(1);
        y1        = SZ_W'(y_reg) + SZ_W'(1);
        band_mh   = BPW'(band_inc) * BPW'(h_eff);
        band_y1r  = BPW'(y1) * BPW'(r_eff);
        band_y2r  = band_y1r + BPW'(r_eff);
        band_step = row_start_reg && (band_inc < r_eff) && (band_mh < band_y1r);
        // this row is the last of the band when floor((band+1)*H/R) == y+1
        band_end  = (band_y1r <= band_mh) && (band_mh < band_y2r);

        last_col  = (x1 == w_eff);
        last_row  = (y1 == h_eff);
        shape_err = (BPW'(h_eff) < BPW'(r_eff));

        k_inc     = GC_W'(k_reg) + GC_W'(1);
        k_last    = (k_inc == c_eff);
    end

    assign pixel_accept = pixel.valid && pixel.ready;
    assign pixel.ready  = (state_reg == S_IDLE);
    assign out_load     = (state_reg == S_EMIT_OUT) && (!out_valid_reg || grid.ready);

    // Hold the accepted pixel for the luma pipeline.
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            word_reg <= pixel.pixel_word;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: position, read-modify-write, then band emission.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            x_reg          <= '0;
            y_reg          <= '0;
            cc_reg         <= '0;
            band_reg       <= '0;
            k_reg          <= '0;
            row_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_bright_reg <= '0;
            out_last_reg   <= 1'b0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_row_reg    <= ROW_FW'(band_reg);
                out_col_reg    <= COL_FW'(k_reg);
                out_bright_reg <= div_quot;
                out_last_reg   <= k_last;
                out_err_reg    <= shape_err;
            end
            else if (grid.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // restart the image on any register write
            if (cfg_restart)
            begin
                x_reg    <= '0;
                y_reg    <= '0;
                cc_reg   <= '0;
                band_reg <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (pixel_accept)
                        begin
                            row_start_reg <= (x_reg == '0);
                            if (x_reg == '0)
                            begin
                                cc_reg <= '0;
                                if (y_reg == '0)
                                begin
                                    band_reg <= '0;
                                end
                            end
                            state_reg <= S_POS;
                        end
                    end
                    S_POS:
                    begin
                        // step one column and one band boundary per cycle until the pixel's cell is found
                        if (col_step)
                        begin
                            cc_reg <= CI_W'(cc_inc);
                        end
                        if (band_step)
                        begin
                            band_reg <= BI_W'(band_inc);
                        end
                        if (!col_step && !band_step)
                        begin
                            state_reg <= S_READ;
                        end
                    end
                    S_READ:
                    begin
                        state_reg <= S_UPDATE;
                    end
                    S_UPDATE:
                    begin
                        if (last_col)
                        begin
                            x_reg <= '0;
                            y_reg <= last_row ? '0 : XW'(y1);
                        end
                        else
                        begin
                            x_reg <= XW'(x1);
                        end
                        if (last_col && band_end)
                        begin
                            k_reg     <= '0;
                            state_reg <= S_EMIT_RD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_EMIT_RD:
                    begin
                        state_reg <= S_EMIT_LD;
                    end
                    S_EMIT_LD:
                    begin
                        state_reg <= S_EMIT_DIV;
                    end
                    S_EMIT_DIV:
                    begin
                        if (div_done)
                        begin
                            state_reg <= S_EMIT_OUT;
                        end
                    end
                    S_EMIT_OUT:
                    begin
                        if (out_load)
                        begin
                            if (k_last)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                k_reg     <= CI_W'(k_inc);
                                state_reg <= S_EMIT_RD;
                            end
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Cell memory access. Emission reads each cell and drops its valid
    // bit, which empties the band for the next one.
    // ---------------------------------------------------------------
    always_comb
    begin
        store_cmd.rd_en   = (state_reg == S_READ) || (state_reg == S_EMIT_RD);
        store_cmd.wr_en   = (state_reg == S_UPDATE);
        store_cmd.clr_one = (state_reg == S_EMIT_LD);
        store_cmd.clr_all = cfg_restart;
        case (state_reg)
            S_EMIT_RD, S_EMIT_LD: store_addr = k_reg;
            default:              store_addr = cc_reg;
        endcase
        wr_sum   = rd_sum + SUM_W'(luma);
        wr_count = rd_count + CNT_W'(1);
    end

    plbd_luma u_luma (
        .clk          (clk),
        .pixel_word   (word_reg),
        .pixel_format (pixel_format_t'(fmt_reg)),
        .luma         (luma)
    );

    plbd_cell_store #(
        .DEPTH (MAX_GRID_COLUMNS),
        .AW    (CI_W),
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_cell_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (store_cmd),
        .addr     (store_addr),
        .wr_sum   (wr_sum),
        .wr_count (wr_count),
        .rd_sum   (rd_sum),
        .rd_count (rd_count)
    );

    plbd_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_EMIT_LD),
        .num   (rd_sum),
        .den   (rd_count),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign grid.valid           = out_valid_reg;
    assign grid.cell_row        = out_row_reg;
    assign grid.cell_column     = out_col_reg;
    assign grid.cell_brightness = out_bright_reg;
    assign grid.last_in_band    = out_last_reg;
    assign grid.shape_error     = out_err_reg;

    `PLBD_ASSERT_NXT(a_one_pixel_at_a_time, pixel_accept, !pixel.ready, "pixel taken while busy")
    `PLBD_ASSERT_NXT(a_cfg_restart, cfg_restart, x_reg == '0 && y_reg == '0 && cc_reg == '0, "restart missed")
    `PLBD_ASSERT_IMP(a_div_done_in_wait, div_done, state_reg == S_EMIT_DIV, "quotient arrived unawaited")

endmodule

// File: rtl/core/plbd_luma.sv
module plbd_luma (
    input  logic                            clk,
    input  logic [plbd_pkg::PIXEL_W-1:0]    pixel_word,
    input  plbd_pkg::pixel_format_t         pixel_format,
    output logic [plbd_pkg::BRIGHT_W-1:0]   luma
);
    import plbd_pkg::*;

    logic [4:0]  r5;
    logic [5:0]  g6;
    logic [4:0]  b5;
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [15:0] sum565;
    logic [15:0] sum8888;
    logic [7:0]  l_next;
    logic [7:0]  l1_reg;
    logic [7:0]  a1_reg;
    logic        argb1_reg;
    logic [15:0] prod2_reg;
    logic [7:0]  l2_reg;
    logic        argb2_reg;
    logic [16:0] scaled;

    always_comb
    begin
        r5 = pixel_word[15:11] & RB5_MASK;
        g6 = pixel_word[10:5] & G6_MASK;
        b5 = pixel_word[4:0] & RB5_MASK;
        // widen each channel by bit replication
        r8 = {r5, r5[4:2]};
        g8 = {g6, g6[5:4]};
        b8 = {b5, b5[4:2]};
        sum565 = 16'(r8) * 16'(LUMA_R_WEIGHT) + 16'(g8) * 16'(LUMA_G_WEIGHT)
               + 16'(b8) * 16'(LUMA_B_WEIGHT);
        sum8888 = 16'(pixel_word[23:16]) * 16'(LUMA_R_WEIGHT)
                + 16'(pixel_word[15:8]) * 16'(LUMA_G_WEIGHT)
                + 16'(pixel_word[7:0]) * 16'(LUMA_B_WEIGHT);
        case (pixel_format)
            FMT_RGB565:   l_next = sum565[15:8];
            FMT_ARGB8888: l_next = sum8888[15:8];
            default:      l_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        l1_reg    <= l_next;
        a1_reg    <= pixel_word[31:24];
        argb1_reg <= (pixel_format == FMT_ARGB8888);
        prod2_reg <= 16'(l1_reg) * 16'(a1_reg);
        l2_reg    <= l1_reg;
        argb2_reg <= argb1_reg;
    end

    // divide by 255: exact for products up to 255 * 255
    assign scaled = 17'(prod2_reg) + 17'(prod2_reg >> 8) + 17'd1;
    assign luma   = argb2_reg ? 8'(scaled >> 8) : l2_reg;

endmodule

// File: rtl/core/plbd_div.sv
`include "pixel_luma_box_downscale_defines.svh"

module plbd_div #(
    parameter int SUM_W = 28,
    parameter int CNT_W = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SUM_W-1:0]              num,
    input  logic [CNT_W-1:0]              den,
    output logic                          done,
    output logic [plbd_pkg::BRIGHT_W-1:0] quot
);
    import plbd_pkg::*;

    localparam int DW     = CNT_W + BRIGHT_W;
    localparam int STEP_W = $clog2(BRIGHT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     den_reg;
    logic [BRIGHT_W-1:0] quot_reg;
    logic              zero_reg;
    logic              fits;

    assign fits = (rem_reg >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(BRIGHT_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle, most significant first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= DW'(num);
            den_reg  <= DW'(den) << (BRIGHT_W - 1);
            quot_reg <= '0;
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - den_reg;
            end
            quot_reg <= {quot_reg[BRIGHT_W-2:0], fits};
            den_reg  <= den_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : quot_reg;

    `PLBD_ASSERT_IMP(a_div_no_restart, start, !busy_reg, "divider restarted while busy")
    `PLBD_ASSERT_NXT(a_div_start_busy, start, busy_reg, "divider failed to start")
    `PLBD_ASSERT_NXT(a_div_finish, busy_reg && !start && step_reg == '0, done_reg, "divider missed done")

endmodule

// File: rtl/core/plbd_cell_store.sv
module plbd_cell_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int SUM_W = 28,
    parameter int CNT_W = 21
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  plbd_pkg::store_cmd_t cmd,
    input  logic [AW-1:0]        addr,
    input  logic [SUM_W-1:0]     wr_sum,
    input  logic [CNT_W-1:0]     wr_count,
    output logic [SUM_W-1:0]     rd_sum,
    output logic [CNT_W-1:0]     rd_count
);
    import plbd_pkg::*;

    localparam int EW = SUM_W + CNT_W;

    logic [EW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [EW-1:0]    rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= {wr_sum, wr_count};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // an entry without its valid bit reads as an empty cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
            if (cmd.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            else if (cmd.clr_one)
            begin
                valid_reg[addr] <= 1'b0;
            end
        end
    end

    assign rd_sum   = rd_valid_reg ? rd_data_reg[EW-1:CNT_W] : '0;
    assign rd_count = rd_valid_reg ? rd_data_reg[CNT_W-1:0] : '0;

endmodule
